### rtl/core/sapp_pkg.sv
// ----------------------------------------------------------------------------
// sapp_pkg: six-axis puck packet parser definitions
// Packet kinds, protocol characters and the digit code table.
// ----------------------------------------------------------------------------
package sapp_pkg;

   localparam logic [7:0] TermChar   = 8'h0d;
   localparam logic [7:0] LeadMotion = 8'h64;  // 'd'
   localparam logic [7:0] LeadKey    = 8'h6b;  // 'k'

   localparam int unsigned NumDigits = 24;
   localparam logic [4:0]  MaxCount  = 5'd25;
   localparam logic [15:0] AxisOffset = 16'h8000;

   typedef enum logic [1:0] {
      KIND_MOTION = 2'd0,
      KIND_KEY    = 2'd1,
      KIND_OTHER  = 2'd2
   } kind_type;

   function automatic logic [3:0] digit_value(input logic [7:0] c);
      logic [3:0] v;
      case (c)
         8'h30:   v = 4'd0;   // '0'
         8'h41:   v = 4'd1;   // 'A'
         8'h42:   v = 4'd2;   // 'B'
         8'h33:   v = 4'd3;   // '3'
         8'h44:   v = 4'd4;   // 'D'
         8'h35:   v = 4'd5;   // '5'
         8'h36:   v = 4'd6;   // '6'
         8'h47:   v = 4'd7;   // 'G'
         8'h48:   v = 4'd8;   // 'H'
         8'h39:   v = 4'd9;   // '9'
         8'h3a:   v = 4'd10;  // ':'
         8'h4b:   v = 4'd11;  // 'K'
         8'h3c:   v = 4'd12;  // '<'
         8'h4d:   v = 4'd13;  // 'M'
         8'h4e:   v = 4'd14;  // 'N'
         8'h3f:   v = 4'd15;  // '?'
         default: v = 4'd0;
      endcase
      return v;
   endfunction

endpackage

### rtl/core/six_axis_puck_packet_parser.sv
// ----------------------------------------------------------------------------
// six_axis_puck_packet_parser
// A terminator beat passes from the input register to the result register.
// Throughput: one byte per cycle, but a terminator waits on a stalled result;
//   one pass decodes a byte from the input register into held and result regs.
// Reset (synchronous, active high) clears packet state, held axes and buttons.
// ----------------------------------------------------------------------------
// Decodes carriage-return terminated packets: 'd' motion and 'k' key packets.
// ----------------------------------------------------------------------------
module six_axis_puck_packet_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_packet_kind,
   output logic signed [15:0] rsp_trans_x,
   output logic signed [15:0] rsp_trans_y,
   output logic signed [15:0] rsp_trans_z,
   output logic signed [15:0] rsp_rot_x,
   output logic signed [15:0] rsp_rot_y,
   output logic signed [15:0] rsp_rot_z,
   output logic [8:0]         rsp_button_bits
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;

   logic [4:0]  char_index_ff, char_index_in;
   logic [7:0]  lead_char_ff, lead_char_in;
   logic [3:0]  nibble_ff [sapp_pkg::NumDigits];
   logic [3:0]  nibble_in [sapp_pkg::NumDigits];
   logic [15:0] trans_ff [3];
   logic [15:0] trans_in [3];
   logic [15:0] axis [6];
   logic [8:0]  buttons_ff, buttons_in;

   logic        out_valid_ff;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [15:0] out_rot_ff [3];
   logic [15:0] out_rot_in [3];

   logic        is_term;
   logic        advance;
   logic [3:0]  dval;

   assign is_term   = (in_byte_ff == sapp_pkg::TermChar);
   assign advance   = in_valid_ff && (!is_term || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign dval      = sapp_pkg::digit_value(in_byte_ff);

   always_comb begin
      for (int a = 0; a < 6; a++) begin
         axis[a] = {nibble_ff[4*a], nibble_ff[4*a+1], nibble_ff[4*a+2],
                    nibble_ff[4*a+3]} ^ sapp_pkg::AxisOffset;
      end
   end

   always_comb begin
      char_index_in = char_index_ff;
      lead_char_in  = lead_char_ff;
      buttons_in    = buttons_ff;
      out_kind_in   = sapp_pkg::KIND_OTHER;
      for (int i = 0; i < sapp_pkg::NumDigits; i++) begin
         nibble_in[i] = nibble_ff[i];
      end
      for (int i = 0; i < 3; i++) begin
         trans_in[i]   = trans_ff[i];
         out_rot_in[i] = 16'd0;
      end
      if (is_term) begin
         if (lead_char_ff == sapp_pkg::LeadMotion) begin
            out_kind_in = sapp_pkg::KIND_MOTION;
            for (int i = 0; i < 3; i++) begin
               trans_in[i]   = axis[i];
               out_rot_in[i] = axis[i+3];
            end
         end else if (lead_char_ff == sapp_pkg::LeadKey) begin
            out_kind_in = sapp_pkg::KIND_KEY;
            buttons_in  = {nibble_ff[2][0], nibble_ff[1], nibble_ff[0]};
         end
         char_index_in = 5'd0;
         lead_char_in  = 8'd0;
         for (int i = 0; i < sapp_pkg::NumDigits; i++) begin
            nibble_in[i] = 4'd0;
         end
      end else begin
         if (char_index_ff == 5'd0) begin
            lead_char_in = in_byte_ff;
         end
         for (int i = 0; i < sapp_pkg::NumDigits; i++) begin
            if (char_index_ff == 5'(i + 1)) begin
               nibble_in[i] = dval;
            end
         end
         if (char_index_ff < sapp_pkg::MaxCount) begin
            char_index_in = char_index_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         char_index_ff <= 5'd0;
         lead_char_ff  <= 8'd0;
         buttons_ff    <= 9'd0;
         for (int i = 0; i < sapp_pkg::NumDigits; i++) begin
            nibble_ff[i] <= 4'd0;
         end
         for (int i = 0; i < 3; i++) begin
            trans_ff[i] <= 16'd0;
         end
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff <= (out_valid_ff && !rsp_ready) || (advance && is_term);
         if (advance) begin
            char_index_ff <= char_index_in;
            lead_char_ff  <= lead_char_in;
            buttons_ff    <= buttons_in;
            for (int i = 0; i < sapp_pkg::NumDigits; i++) begin
               nibble_ff[i] <= nibble_in[i];
            end
            for (int i = 0; i < 3; i++) begin
               trans_ff[i] <= trans_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && is_term) begin
         out_kind_ff <= out_kind_in;
         for (int i = 0; i < 3; i++) begin
            out_rot_ff[i] <= out_rot_in[i];
         end
      end
   end

   // held values in the result beat are copied from the next held state;
   // they change only when a terminator loads a new result
   logic [15:0] rsp_trans_ff [3];
   logic [8:0]  rsp_buttons_ff;

   always_ff @(posedge clock) begin
      if (advance && is_term) begin
         rsp_buttons_ff <= buttons_in;
         for (int i = 0; i < 3; i++) begin
            rsp_trans_ff[i] <= trans_in[i];
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_packet_kind = out_kind_ff;
   assign rsp_trans_x     = rsp_trans_ff[0];
   assign rsp_trans_y     = rsp_trans_ff[1];
   assign rsp_trans_z     = rsp_trans_ff[2];
   assign rsp_rot_x       = out_rot_ff[0];
   assign rsp_rot_y       = out_rot_ff[1];
   assign rsp_rot_z       = out_rot_ff[2];
   assign rsp_button_bits = rsp_buttons_ff;

endmodule
